// File: hw/rtl/pbc_pkg.sv
// Shared widths, types and constants for the pixel brightness converter.
package pbc_pkg;

  localparam int unsigned ColorW  = 15;
  localparam int unsigned ChanW   = 5;
  localparam int unsigned BrightW = 4;
  localparam int unsigned PixelW  = 16;
  localparam int unsigned NumChan = 3;

  // Product of a channel and a brightness nibble.
  localparam int unsigned ProdW = ChanW + BrightW;

  // Largest product: full channel times full brightness.
  localparam logic [ProdW-1:0] ProdMax = ProdW'(31 * 15);

  // Brightness that leaves a channel unchanged, used as the divisor.
  localparam logic [BrightW-1:0] BrightFull = BrightW'(15);

  typedef logic [ProdW-1:0] prod_t;
  typedef logic [ChanW-1:0] chan_t;

endpackage

// File: hw/rtl/pixel_brightness_convert.sv
// Top level of the pixel brightness converter: three-stage scale and pack pipeline.
//
// This block takes one 15-bit pixel word per clock when not stalled (three 5-bit
// channels, low channel in bits 4:0) together with its line's 4-bit brightness and
// its valid mask bit, and returns one 16-bit 5-6-5 word per pixel. Each channel is
// scaled as channel * brightness / 15, rounded down. The low channel lands in bits
// 15:11, the middle channel in bits 10:6 with its top bit repeated in bit 5, and the
// high channel in bits 4:0. With gate_enable set, a pixel whose valid bit is clear
// comes out as zero. The pipeline accepts a new word in every cycle while the output
// is not stalled and holds up to three words; a word passes through the product,
// quotient and pixel registers before its result appears. The three stages are the
// channel multiply, the divide by 15 (a multiply by 17/256 followed by a remainder
// check), and the final correction and packing into the output register. A stall
// on the output propagates back through the stages that are full, so a bubble in
// the pipeline is always filled first.
// The gate_enable register is written through its own valid/ready port,
// which is always ready; write it only while the pipeline is empty.
module pixel_brightness_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pbc_pkg::ColorW-1:0]      raw_color_i,
  input  logic [pbc_pkg::BrightW-1:0]     line_brightness_i,
  input  logic                            valid_bit_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pbc_pkg::PixelW-1:0]      out_pixel_o,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i
);

  localparam int unsigned NumChan = pbc_pkg::NumChan;
  localparam int unsigned ChanW   = pbc_pkg::ChanW;
  localparam int unsigned ProdW   = pbc_pkg::ProdW;
  // Width of product * 17, enough for the largest product.
  localparam int unsigned MulW    = ProdW + 5;

  // Configuration register.
  logic gate_enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gate_enable_q <= cfg_data_i;
    end
  end

  // Stage valid bits and the ready chain. A stage may load when it is empty
  // or when the stage after it moves on in the same cycle.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  logic in_accept;
  assign in_accept = in_valid_i && rdy1;

  // Stage 1: multiply each channel by the brightness. A gated pixel gets a
  // product of zero, which yields a black output.
  pbc_pkg::prod_t prod_d [NumChan];
  pbc_pkg::prod_t prod_q [NumChan];
  logic           masked;

  assign masked = gate_enable_q && !valid_bit_i;

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      prod_d[k] = masked ? '0
                : ProdW'(raw_color_i[k*ChanW +: ChanW]) * ProdW'(line_brightness_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prod_q <= prod_d;
    end
  end

  // Stage 2: estimate the quotient by 15 as (p * 17) >> 8, which is never
  // high and at most one low, then flag the case where the remainder shows
  // the estimate needs one more.
  pbc_pkg::chan_t quo_d [NumChan];
  pbc_pkg::chan_t quo_q [NumChan];
  logic           fix_d [NumChan];
  logic           fix_q [NumChan];

  always_comb begin
    logic [MulW-1:0]  mul17;
    logic [ProdW-1:0] back;
    logic [ProdW-1:0] rem;
    for (int k = 0; k < NumChan; k++) begin
      mul17    = (MulW'(prod_q[k]) << 4) + MulW'(prod_q[k]);
      quo_d[k] = mul17[8 +: ChanW];
      back     = (ProdW'(quo_d[k]) << 4) - ProdW'(quo_d[k]);
      rem      = prod_q[k] - back;
      fix_d[k] = (rem >= ProdW'(pbc_pkg::BrightFull));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      quo_q <= quo_d;
      fix_q <= fix_d;
    end
  end

  // Stage 3: apply the correction and pack the 5-6-5 word.
  pbc_pkg::chan_t                chan_fin [NumChan];
  logic [pbc_pkg::PixelW-1:0]    pixel_d;
  logic [pbc_pkg::PixelW-1:0]    pixel_q;

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      chan_fin[k] = quo_q[k] + ChanW'(fix_q[k]);
    end
    pixel_d = {chan_fin[0], chan_fin[1], chan_fin[1][ChanW-1], chan_fin[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pixel_o = pixel_q;

  // A product never exceeds a full channel times full brightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (prod_q[0] <= pbc_pkg::ProdMax) && (prod_q[1] <= pbc_pkg::ProdMax)
             && (prod_q[2] <= pbc_pkg::ProdMax))
    else $error("stage 1 product out of range");

  // The corrected quotient must still fit in a channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((6'(quo_q[0]) + 6'(fix_q[0])) <= 6'd31)
             && ((6'(quo_q[1]) + 6'(fix_q[1])) <= 6'd31)
             && ((6'(quo_q[2]) + 6'(fix_q[2])) <= 6'd31))
    else $error("quotient correction overflowed");

  // An accepted word with zero brightness gives all-zero products.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (line_brightness_i == '0)) |=>
      (prod_q[0] == '0) && (prod_q[1] == '0) && (prod_q[2] == '0))
    else $error("zero brightness did not give zero products");

  // A gated word gives all-zero products.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && gate_enable_q && !valid_bit_i) |=>
      (prod_q[0] == '0) && (prod_q[1] == '0) && (prod_q[2] == '0))
    else $error("masked pixel was not blanked");

  // The middle channel's top bit is repeated into bit 5.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_pixel_o[5] == out_pixel_o[10]))
    else $error("middle channel replica bit mismatch");

endmodule
